[hdl/elot_pkg.sv]
`timescale 1ns / 1ps

package elot_pkg;

  localparam int unsigned MAX_EXTENTS_DEF = 16;

  localparam int unsigned SRC_W    = 8;
  localparam int unsigned START_W  = 48;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned OFS_W    = 36;
  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] STS_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EOF    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_SEALED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL   = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SEAL  = 2'd2,
    OP_READ  = 2'd3
  } elot_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } elot_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_simple;
    logic start_walk;
    logic emit_eof;
    logic emit_seg;
    logic advance;
    logic walking;
  } elot_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eof_early;
    logic zero_len;
    logic beyond;
    logic skip;
    logic seg_final;
  } elot_sts_t;

endpackage

[hdl/extent_list_offset_translator.sv]
// Add, clear, seal and reads that end at once: result loaded at the transfer edge; one such item
// per cycle while the output is not stalled. A read walks the extent table one entry per
// cycle, one registered memory read each, skipping extents behind the offset and emitting a
// segment per touched one, then EOF if it runs past the last; a stalled output holds the walk
// at a touched extent or EOF. No new item is taken until the read's final result is loaded.
// rst_ni (asynchronous, active low) empties and unseals the table; entries are not cleared.
`timescale 1ns / 1ps

module extent_list_offset_translator #(
  parameter int unsigned MAX_EXTENTS = elot_pkg::MAX_EXTENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [elot_pkg::SRC_W-1:0]    source_id_i,
  input  logic [elot_pkg::START_W-1:0]  region_start_i,
  input  logic [elot_pkg::LEN_W-1:0]    region_length_i,
  input  logic [elot_pkg::OFS_W-1:0]    read_offset_i,
  input  logic [elot_pkg::LEN_W-1:0]    read_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [elot_pkg::SRC_W-1:0]    seg_source_o,
  output logic [elot_pkg::LEN_W-1:0]    seg_source_offset_o,
  output logic [elot_pkg::LEN_W-1:0]    seg_length_o,
  output logic [elot_pkg::LEN_W-1:0]    bytes_done_o,
  output logic [elot_pkg::OFS_W-1:0]    object_size_o,
  output logic [elot_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);

  elot_pkg::elot_cmd_t cmd;
  elot_pkg::elot_sts_t sts;

  elot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  elot_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .op_i                (op_i),
    .source_id_i         (source_id_i),
    .region_start_i      (region_start_i),
    .region_length_i     (region_length_i),
    .read_offset_i       (read_offset_i),
    .read_length_i       (read_length_i),
    .seg_source_o        (seg_source_o),
    .seg_source_offset_o (seg_source_offset_o),
    .seg_length_o        (seg_length_o),
    .bytes_done_o        (bytes_done_o),
    .object_size_o       (object_size_o),
    .status_o            (status_o),
    .last_o              (last_o)
  );

endmodule

[hdl/elot_ctrl.sv]
`timescale 1ns / 1ps

module elot_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  elot_pkg::elot_sts_t sts_i,
  output elot_pkg::elot_cmd_t cmd_o
);

  elot_pkg::elot_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  logic                  accept;
  logic                  quick;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == elot_pkg::S_IDLE) && in_valid_i && out_free;
  // a read that ends before touching the table answers at once
  assign quick    = (elot_pkg::elot_op_e'(op_i) != elot_pkg::OP_READ) ||
                    sts_i.eof_early || sts_i.zero_len;

  always_comb begin
    state_d = state_q;
    case (state_q)
      elot_pkg::S_IDLE: begin
        if (accept && !quick) state_d = elot_pkg::S_WALK;
      end
      elot_pkg::S_WALK: begin
        if (sts_i.beyond) begin
          if (out_free) state_d = elot_pkg::S_IDLE;
        end else if (!sts_i.skip && out_free && sts_i.seg_final) begin
          state_d = elot_pkg::S_IDLE;
        end
      end
      default: state_d = elot_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.walking = (state_q == elot_pkg::S_WALK);
    in_stall_o    = !((state_q == elot_pkg::S_IDLE) && out_free);
    case (state_q)
      elot_pkg::S_IDLE: begin
        cmd_o.load_simple = accept && quick;
        cmd_o.start_walk  = accept && !quick;
      end
      elot_pkg::S_WALK: begin
        if (sts_i.beyond) begin
          cmd_o.emit_eof = out_free;
        end else if (sts_i.skip) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.emit_seg = out_free;
          cmd_o.advance  = out_free;
        end
      end
      default: ;
    endcase
    if (cmd_o.load_simple || cmd_o.emit_eof || cmd_o.emit_seg) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= elot_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/elot_dp.sv]
`timescale 1ns / 1ps

module elot_dp #(
  parameter int unsigned MAX_EXTENTS = elot_pkg::MAX_EXTENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  elot_pkg::elot_cmd_t                 cmd_i,
  output elot_pkg::elot_sts_t                 sts_o,
  input  logic [1:0]                          op_i,
  input  logic [elot_pkg::SRC_W-1:0]          source_id_i,
  input  logic [elot_pkg::START_W-1:0]        region_start_i,
  input  logic [elot_pkg::LEN_W-1:0]          region_length_i,
  input  logic [elot_pkg::OFS_W-1:0]          read_offset_i,
  input  logic [elot_pkg::LEN_W-1:0]          read_length_i,
  output logic [elot_pkg::SRC_W-1:0]          seg_source_o,
  output logic [elot_pkg::LEN_W-1:0]          seg_source_offset_o,
  output logic [elot_pkg::LEN_W-1:0]          seg_length_o,
  output logic [elot_pkg::LEN_W-1:0]          bytes_done_o,
  output logic [elot_pkg::OFS_W-1:0]          object_size_o,
  output logic [elot_pkg::STATUS_W-1:0]       status_o,
  output logic                                last_o
);

  localparam int unsigned CW    = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned IW    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned SW    = elot_pkg::SRC_W;
  localparam int unsigned LW    = elot_pkg::LEN_W;
  localparam int unsigned OW    = elot_pkg::OFS_W;
  localparam int unsigned EW    = OW + 1;
  localparam int unsigned STW   = elot_pkg::STATUS_W;

  // extent table: source id, (base - object start) mod 2^32, object end
  logic [SW-1:0] src_mem [MAX_EXTENTS];
  logic [LW-1:0] adj_mem [MAX_EXTENTS];
  logic [EW-1:0] end_mem [MAX_EXTENTS];

  logic [SW-1:0] rd_src_q;
  logic [LW-1:0] rd_adj_q;
  logic [EW-1:0] rd_end_q;

  logic [CW-1:0] count_q, count_d;
  logic [OW-1:0] total_q, total_d;
  logic          sealed_q, sealed_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [EW-1:0] offset_q, offset_d;
  logic [LW-1:0] remain_q, remain_d;
  logic [LW-1:0] done_q, done_d;

  logic [SW-1:0]  seg_source_q;
  logic [LW-1:0]  seg_source_offset_q;
  logic [LW-1:0]  seg_length_q;
  logic [LW-1:0]  bytes_done_q;
  logic [OW-1:0]  object_size_q;
  logic [STW-1:0] status_q;
  logic           last_q;

  elot_pkg::elot_op_e op;
  logic               full;
  logic               add_ok;
  logic [EW-1:0]      new_end;
  logic [IW-1:0]      wr_idx;
  logic [IW-1:0]      rd_idx;
  logic [EW:0]        diff;
  logic [EW-1:0]      avail;
  logic               seg_final;
  logic [LW-1:0]      seg;
  logic [LW-1:0]      done_next;
  logic [STW-1:0]     simple_status;
  logic [OW-1:0]      simple_size;

  assign op      = elot_pkg::elot_op_e'(op_i);
  assign full    = (count_q == CW'(MAX_EXTENTS));
  assign add_ok  = cmd_i.load_simple && (op == elot_pkg::OP_ADD) && !sealed_q && !full;
  assign new_end = {1'b0, total_q} + EW'(region_length_i);
  assign wr_idx  = count_q[IW-1:0];

  // entry under the walk pointer: end <= offset means it lies behind us
  assign diff      = {1'b0, rd_end_q} - {1'b0, offset_q};
  assign avail     = diff[EW-1:0];
  assign seg_final = (EW'(remain_q) <= avail);
  assign seg       = seg_final ? remain_q : avail[LW-1:0];
  assign done_next = done_q + seg;

  assign sts_o.eof_early = (read_offset_i >= total_q);
  assign sts_o.zero_len  = (read_length_i == '0);
  assign sts_o.beyond    = (cur_q >= count_q);
  assign sts_o.skip      = diff[EW] || (diff == '0);
  assign sts_o.seg_final = seg_final;

  always_comb begin
    if (!cmd_i.walking) begin
      cur_d = '0;
    end else if (cmd_i.advance) begin
      cur_d = cur_q + CW'(1);
    end else begin
      cur_d = cur_q;
    end
    rd_idx = (cur_d < CW'(MAX_EXTENTS)) ? cur_d[IW-1:0] : '0;
  end

  always_comb begin
    simple_size = total_q;
    case (op)
      elot_pkg::OP_ADD: begin
        if (sealed_q) begin
          simple_status = elot_pkg::STS_SEALED;
        end else if (full) begin
          simple_status = elot_pkg::STS_FULL;
        end else begin
          simple_status = elot_pkg::STS_OK;
          simple_size   = new_end[OW-1:0];
        end
      end
      elot_pkg::OP_CLEAR: begin
        simple_status = elot_pkg::STS_OK;
        simple_size   = '0;
      end
      elot_pkg::OP_SEAL: begin
        simple_status = (count_q == '0) ? elot_pkg::STS_EMPTY : elot_pkg::STS_OK;
      end
      elot_pkg::OP_READ: begin
        simple_status = sts_o.eof_early ? elot_pkg::STS_EOF : elot_pkg::STS_OK;
      end
      default: simple_status = elot_pkg::STS_OK;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    total_d  = total_q;
    sealed_d = sealed_q;
    offset_d = offset_q;
    remain_d = remain_q;
    done_d   = done_q;
    if (add_ok) begin
      count_d = count_q + CW'(1);
      total_d = new_end[OW-1:0];
    end
    if (cmd_i.load_simple && (op == elot_pkg::OP_CLEAR)) begin
      count_d  = '0;
      total_d  = '0;
      sealed_d = 1'b0;
    end
    if (cmd_i.load_simple && (op == elot_pkg::OP_SEAL) && (count_q != '0)) begin
      sealed_d = 1'b1;
    end
    if (cmd_i.start_walk) begin
      offset_d = {1'b0, read_offset_i};
      remain_d = read_length_i;
      done_d   = '0;
    end
    if (cmd_i.emit_seg) begin
      offset_d = offset_q + EW'(seg);
      remain_d = remain_q - seg;
      done_d   = done_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      sealed_q <= 1'b0;
      cur_q    <= '0;
    end else begin
      count_q  <= count_d;
      total_q  <= total_d;
      sealed_q <= sealed_d;
      cur_q    <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    remain_q <= remain_d;
    done_q   <= done_d;
  end

  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      src_mem[wr_idx] <= source_id_i;
      adj_mem[wr_idx] <= region_start_i[LW-1:0] - total_q[LW-1:0];
      end_mem[wr_idx] <= new_end;
    end
    rd_src_q <= src_mem[rd_idx];
    rd_adj_q <= adj_mem[rd_idx];
    rd_end_q <= end_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_simple) begin
      seg_source_q        <= '0;
      seg_source_offset_q <= '0;
      seg_length_q        <= '0;
      bytes_done_q        <= '0;
      object_size_q       <= simple_size;
      status_q            <= simple_status;
      last_q              <= 1'b1;
    end else if (cmd_i.emit_eof) begin
      seg_source_q        <= '0;
      seg_source_offset_q <= '0;
      seg_length_q        <= '0;
      bytes_done_q        <= done_q;
      object_size_q       <= total_q;
      status_q            <= elot_pkg::STS_EOF;
      last_q              <= 1'b1;
    end else if (cmd_i.emit_seg) begin
      seg_source_q        <= rd_src_q;
      seg_source_offset_q <= offset_q[LW-1:0] + rd_adj_q;
      seg_length_q        <= seg;
      bytes_done_q        <= done_next;
      object_size_q       <= total_q;
      status_q            <= elot_pkg::STS_OK;
      last_q              <= seg_final;
    end
  end

  assign seg_source_o        = seg_source_q;
  assign seg_source_offset_o = seg_source_offset_q;
  assign seg_length_o        = seg_length_q;
  assign bytes_done_o        = bytes_done_q;
  assign object_size_o       = object_size_q;
  assign status_o            = status_q;
  assign last_o              = last_q;

endmodule

[hdl/elot_chk.sv]
`timescale 1ns / 1ps

module elot_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [elot_pkg::SRC_W-1:0]    seg_source_o,
  input logic [elot_pkg::LEN_W-1:0]    seg_source_offset_o,
  input logic [elot_pkg::LEN_W-1:0]    seg_length_o,
  input logic [elot_pkg::LEN_W-1:0]    bytes_done_o,
  input logic [elot_pkg::STATUS_W-1:0] status_o,
  input logic                          last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(seg_length_o) &&
      $stable(bytes_done_o) && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // only ok segments may be followed by more results of the same item
  a_mid_is_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == elot_pkg::STS_OK && seg_length_o != '0)
    else $error("non-final result is not a segment");

  // status-only results carry no segment and close the item
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != elot_pkg::STS_OK |-> last_o && seg_length_o == '0 &&
      seg_source_o == '0 && seg_source_offset_o == '0)
    else $error("status result carries segment fields");

  // running byte count always covers the current segment
  a_done_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == elot_pkg::STS_OK |-> seg_length_o <= bytes_done_o)
    else $error("bytes_done below segment length");

endmodule

bind extent_list_offset_translator elot_chk u_elot_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .seg_source_o        (seg_source_o),
  .seg_source_offset_o (seg_source_offset_o),
  .seg_length_o        (seg_length_o),
  .bytes_done_o        (bytes_done_o),
  .status_o            (status_o),
  .last_o              (last_o)
);

[dv/tb_extent_list_offset_translator.sv]
`timescale 1ns / 1ps

module tb_extent_list_offset_translator;
  import elot_pkg::*;

  localparam int unsigned N_EXT      = MAX_EXTENTS_DEF;
  localparam int unsigned RAND_ITEMS = 70;

  typedef struct {
    elot_op_e             op;
    logic [SRC_W-1:0]     src;
    logic [START_W-1:0]   rstart;
    logic [LEN_W-1:0]     rlen;
    logic [OFS_W-1:0]     roff;
    logic [LEN_W-1:0]     rdlen;
  } extent_cmd_t;

  typedef struct {
    logic [SRC_W-1:0]    src;
    logic [LEN_W-1:0]    soff;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    done;
    logic [OFS_W-1:0]    osize;
    logic [STATUS_W-1:0] status;
    logic                last;
  } seg_res_t;

  typedef struct {
    extent_cmd_t         cmd;
    int unsigned         reps;
    bit                  typed;
    logic [STATUS_W-1:0] exp_status;
    logic [OFS_W-1:0]    exp_size;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i = '0;
  logic [SRC_W-1:0]    source_id_i = '0;
  logic [START_W-1:0]  region_start_i = '0;
  logic [LEN_W-1:0]    region_length_i = '0;
  logic [OFS_W-1:0]    read_offset_i = '0;
  logic [LEN_W-1:0]    read_length_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SRC_W-1:0]    seg_source_o;
  logic [LEN_W-1:0]    seg_source_offset_o;
  logic [LEN_W-1:0]    seg_length_o;
  logic [LEN_W-1:0]    bytes_done_o;
  logic [OFS_W-1:0]    object_size_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;

  extent_list_offset_translator #(
    .MAX_EXTENTS(N_EXT)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .source_id_i        (source_id_i),
    .region_start_i     (region_start_i),
    .region_length_i    (region_length_i),
    .read_offset_i      (read_offset_i),
    .read_length_i      (read_length_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .seg_source_o       (seg_source_o),
    .seg_source_offset_o(seg_source_offset_o),
    .seg_length_o       (seg_length_o),
    .bytes_done_o       (bytes_done_o),
    .object_size_o      (object_size_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the extent table
  logic [SRC_W-1:0]   tbl_src   [N_EXT];
  logic [START_W-1:0] tbl_base  [N_EXT];
  logic [LEN_W-1:0]   tbl_len   [N_EXT];
  logic [OFS_W-1:0]   tbl_start [N_EXT];
  int unsigned        tbl_count = 0;
  logic [OFS_W-1:0]   obj_size = '0;
  bit                 tbl_sealed = 1'b0;

  seg_res_t    item_segs[$];
  seg_res_t    expected_segs[$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 76;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void put_seg(logic [SRC_W-1:0] src, logic [LEN_W-1:0] soff,
                                  logic [LEN_W-1:0] len, logic [LEN_W-1:0] done,
                                  logic [STATUS_W-1:0] st, logic lst);
    item_segs.push_back('{src, soff, len, done, obj_size, st, lst});
  endfunction

  // split one command into the results it should produce, updating the shadow table
  function automatic void map_request(extent_cmd_t c);
    longint unsigned pos, want, done, in_ext, avail, seg, soff;
    int unsigned cur;
    item_segs.delete();
    case (c.op)
      OP_ADD: begin
        if (tbl_sealed) begin
          put_seg('0, '0, '0, '0, STS_SEALED, 1'b1);
        end else if (tbl_count >= N_EXT) begin
          put_seg('0, '0, '0, '0, STS_FULL, 1'b1);
        end else begin
          tbl_src[tbl_count]   = c.src;
          tbl_base[tbl_count]  = c.rstart;
          tbl_len[tbl_count]   = c.rlen;
          tbl_start[tbl_count] = obj_size;
          obj_size = obj_size + OFS_W'(c.rlen);
          tbl_count++;
          put_seg('0, '0, '0, '0, STS_OK, 1'b1);
        end
      end
      OP_CLEAR: begin
        tbl_count  = 0;
        obj_size   = '0;
        tbl_sealed = 1'b0;
        put_seg('0, '0, '0, '0, STS_OK, 1'b1);
      end
      OP_SEAL: begin
        if (tbl_count == 0) begin
          put_seg('0, '0, '0, '0, STS_EMPTY, 1'b1);
        end else begin
          tbl_sealed = 1'b1;
          put_seg('0, '0, '0, '0, STS_OK, 1'b1);
        end
      end
      default: begin
        pos  = c.roff;
        want = c.rdlen;
        done = 0;
        cur  = 0;
        if (pos >= obj_size) begin
          put_seg('0, '0, '0, '0, STS_EOF, 1'b1);
          return;
        end
        if (want == 0) begin
          put_seg('0, '0, '0, '0, STS_OK, 1'b1);
          return;
        end
        while (want != 0) begin
          // skip extents that end at or before the current position
          while (cur < tbl_count && 64'(tbl_start[cur]) + 64'(tbl_len[cur]) <= pos)
            cur++;
          if (cur >= tbl_count) begin
            put_seg('0, '0, '0, LEN_W'(done), STS_EOF, 1'b1);
            return;
          end
          in_ext = pos - 64'(tbl_start[cur]);
          avail  = 64'(tbl_len[cur]) - in_ext;
          seg    = (want < avail) ? want : avail;
          soff   = in_ext + 64'(tbl_base[cur]);
          done  += seg;
          want  -= seg;
          pos   += seg;
          put_seg(tbl_src[cur], LEN_W'(soff), LEN_W'(seg), LEN_W'(done), STS_OK, want == 0);
        end
      end
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(extent_cmd_t c, bit typed = 1'b0,
                           logic [STATUS_W-1:0] exp_st = STS_OK,
                           logic [OFS_W-1:0] exp_size = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    op_i            = c.op;
    source_id_i     = c.src;
    region_start_i  = c.rstart;
    region_length_i = c.rlen;
    read_offset_i   = c.roff;
    read_length_i   = c.rdlen;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    map_request(c);
    if (typed)
      expected_segs.push_back('{'0, '0, '0, '0, exp_size, exp_st, 1'b1});
    else
      foreach (item_segs[i]) expected_segs.push_back(item_segs[i]);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    in_valid_i = 1'b0;
    while (expected_segs.size() != 0) @(negedge clk_i);
  endtask

  function automatic longint unsigned pick_upto(longint unsigned n);
    return {$urandom, $urandom} % (n + 1);
  endfunction

  function automatic extent_cmd_t rand_any();
    extent_cmd_t c;
    c.op     = elot_op_e'($urandom_range(3));
    c.src    = SRC_W'($urandom);
    c.rstart = START_W'({$urandom, $urandom});
    c.rlen   = $urandom;
    c.roff   = OFS_W'({$urandom, $urandom});
    c.rdlen  = $urandom;
    return c;
  endfunction

  function automatic extent_cmd_t rand_add();
    extent_cmd_t c;
    c    = rand_any();
    c.op = OP_ADD;
    case ($urandom_range(7))
      0:       c.rlen = '0;
      1:       c.rlen = $urandom;
      2:       c.rlen = $urandom_range(1, 3);
      default: c.rlen = $urandom_range(4, 120);
    endcase
    return c;
  endfunction

  function automatic extent_cmd_t rand_read();
    extent_cmd_t c;
    c    = rand_any();
    c.op = OP_READ;
    case ($urandom_range(7))
      0: ;  // keep the fully random offset
      1, 2: if (tbl_count != 0)
        c.roff = tbl_start[$urandom_range(tbl_count - 1)] + OFS_W'($urandom_range(3));
      default: c.roff = OFS_W'(pick_upto(64'(obj_size) + 4));
    endcase
    case ($urandom_range(7))
      0:       c.rdlen = '0;
      1:       c.rdlen = $urandom;
      default: c.rdlen = $urandom_range(1, 300);
    endcase
    return c;
  endfunction

  always @(negedge clk_i) out_stall_i = ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    seg_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_segs.size() == 0) begin
        flag_mismatch("result with nothing outstanding, status", status_o, 0);
      end else begin
        w = expected_segs.pop_front();
        if (seg_source_o !== w.src)
          flag_mismatch("seg_source", seg_source_o, w.src);
        if (seg_source_offset_o !== w.soff)
          flag_mismatch("seg_source_offset", seg_source_offset_o, w.soff);
        if (seg_length_o !== w.len)
          flag_mismatch("seg_length", seg_length_o, w.len);
        if (bytes_done_o !== w.done)
          flag_mismatch("bytes_done", bytes_done_o, w.done);
        if (object_size_o !== w.osize)
          flag_mismatch("object_size", object_size_o, w.osize);
        if (status_o !== w.status)
          flag_mismatch("status", status_o, w.status);
        if (last_o !== w.last)
          flag_mismatch("last", last_o, w.last);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t    dir_rows[17];
    extent_cmd_t c;
    int unsigned rand_base, phase, new_phase, n_adds, n_reads;

    // columns: command, repeat count, typed-in expectation (status, object size)
    dir_rows = '{
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'h0,          32'h1},
        1,  1'b1, STS_EOF,    36'h0},
      '{'{OP_SEAL,  8'h00, 48'h0,            32'h0,         36'h0,          32'h0},
        1,  1'b1, STS_EMPTY,  36'h0},
      '{'{OP_ADD,   8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 36'h0,        32'h0},
        1,  1'b1, STS_OK,     36'h0_FFFF_FFFF},
      '{'{OP_ADD,   8'h00, 48'h0,            32'h0,         36'h0,          32'h0},
        1,  1'b1, STS_OK,     36'h0_FFFF_FFFF},
      '{'{OP_ADD,   8'h5A, 48'h1234_0000_0010, 32'd100,     36'h0,          32'h0},
        1,  1'b0, STS_OK,     36'h0},
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'h0,          32'h0},
        1,  1'b1, STS_OK,     36'h1_0000_0063},
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'h0_FFFF_FFF0, 32'hFFFF_FFFF},
        1,  1'b0, STS_OK,     36'h0},
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'h1_0000_0031, 32'd10},
        1,  1'b0, STS_OK,     36'h0},
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'hF_FFFF_FFFF, 32'd5},
        1,  1'b1, STS_EOF,    36'h1_0000_0063},
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'h1_0000_0063, 32'd1},
        1,  1'b1, STS_EOF,    36'h1_0000_0063},
      '{'{OP_ADD,   8'h10, 48'hABCD_FFFF_FF00, 32'd7,       36'h0,          32'h0},
        13, 1'b0, STS_OK,     36'h0},
      '{'{OP_ADD,   8'hEE, 48'h5555_5555_5555, 32'd9,       36'h0,          32'h0},
        1,  1'b1, STS_FULL,   36'h1_0000_00BE},
      '{'{OP_READ,  8'h00, 48'h0,            32'h0,         36'h0_FFFF_FFF0, 32'hFFFF_FFFF},
        1,  1'b0, STS_OK,     36'h0},
      '{'{OP_SEAL,  8'h00, 48'h0,            32'h0,         36'h0,          32'h0},
        1,  1'b1, STS_OK,     36'h1_0000_00BE},
      '{'{OP_ADD,   8'h01, 48'h1,            32'd1,         36'h0,          32'h0},
        1,  1'b1, STS_SEALED, 36'h1_0000_00BE},
      '{'{OP_SEAL,  8'h00, 48'h0,            32'h0,         36'h0,          32'h0},
        1,  1'b1, STS_OK,     36'h1_0000_00BE},
      '{'{OP_CLEAR, 8'h00, 48'h0,            32'h0,         36'h0,          32'h0},
        1,  1'b1, STS_OK,     36'h0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      for (int unsigned r = 0; r < dir_rows[i].reps; r++) begin
        c        = dir_rows[i].cmd;
        c.src    = c.src + SRC_W'(r);
        c.rstart = c.rstart + START_W'(r * 256);
        send_item(c, dir_rows[i].typed, dir_rows[i].exp_status, dir_rows[i].exp_size);
      end
    end

    // hold the sender until the table has answered everything
    drain_all();

    rand_base = items_sent;
    phase     = 0;
    while (items_sent - rand_base < RAND_ITEMS) begin
      new_phase = (items_sent - rand_base) * 3 / RAND_ITEMS;
      if (new_phase != phase) begin
        drain_all();
        phase = new_phase;
        send_idle_pct = (phase == 1) ? 76 : 0;
        recv_idle_pct = (phase == 1) ? 19 : 0;
      end
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(rand_any());
      end else begin
        c    = rand_any();
        c.op = OP_CLEAR;
        send_item(c);
        n_adds = ($urandom_range(9) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 5);
        repeat (n_adds) send_item(rand_add());
        if ($urandom_range(1) == 0) begin
          c    = rand_any();
          c.op = OP_SEAL;
          send_item(c);
        end
        n_reads = $urandom_range(2, 5);
        repeat (n_reads) send_item(rand_read());
        if ($urandom_range(3) == 0) send_item(rand_add());
      end
    end

    drain_all();
    repeat (N_EXT + 4) @(posedge clk_i);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
hdl/elot_pkg.sv
hdl/elot_ctrl.sv
hdl/elot_dp.sv
hdl/extent_list_offset_translator.sv
hdl/elot_chk.sv
dv/tb_extent_list_offset_translator.sv
